/* rtl/core/stream_byte_reassembler_assert.svh */
// Assertion macros shared by the stream byte reassembler checkers.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef STREAM_BYTE_REASSEMBLER_ASSERT_SVH
`define STREAM_BYTE_REASSEMBLER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SBR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SBR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sbr_pkg.sv */
// Package for the stream byte reassembler: sizes, controller states and
// the control bundle broadcast to the storage cells. No dependencies.
package sbr_pkg;

  // Window size in bytes, one storage cell per window position.
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_EMIT,
    ST_NONE
  } sbr_state_e;

  // Control broadcast from the controller to every cell.
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_rel;
    logic [7:0]       wr_data;
    logic             probe_load;
    logic             probe_shift;
    logic             shift;
  } sbr_cell_ctl_t;

endpackage

/* rtl/core/sbr_cell.sv */
// One window cell of the reassembler: holds one byte, its held flag and
// a probe bit used to measure the in-order run. Depends on sbr_pkg.
module sbr_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sbr_pkg::sbr_cell_ctl_t     ctl_i,
  input  logic [sbr_pkg::IDX_W-1:0]  idx_i,
  input  logic [7:0]                 nxt_byte_i,
  input  logic                       nxt_held_i,
  input  logic                       nxt_probe_i,
  output logic [7:0]                 byte_o,
  output logic                       held_o,
  output logic                       probe_o,
  output logic                       hit_o
);
  import sbr_pkg::*;

  logic [7:0] byte_q, byte_d;
  logic       held_q, held_d;
  logic       probe_q, probe_d;
  logic       hit;

  // A write lands here only if it targets this position and it is free
  assign hit = ctl_i.wr_en && (ctl_i.wr_rel == idx_i) && !held_q;

  // Next values: shift toward the window front, or take a new byte
  always_comb begin
    byte_d  = byte_q;
    held_d  = held_q;
    probe_d = probe_q;
    if (ctl_i.shift) begin
      byte_d = nxt_byte_i;
      held_d = nxt_held_i;
    end else if (hit) begin
      byte_d = ctl_i.wr_data;
      held_d = 1'b1;
    end
    if (ctl_i.probe_load) begin
      probe_d = held_q | hit;
    end else if (ctl_i.probe_shift) begin
      probe_d = nxt_probe_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      probe_q <= 1'b0;
    end else begin
      held_q  <= held_d;
      probe_q <= probe_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o  = byte_q;
  assign held_o  = held_q;
  assign probe_o = probe_q;
  assign hit_o   = hit;

endmodule

/* rtl/core/sbr_ctrl.sv */
// Controller of the reassembler: window checks, counters, eof tracking,
// the run-length count, draining and the result register. Uses sbr_pkg.
module sbr_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [31:0]                 segment_start_i,
  input  logic [31:0]                 segment_end_i,
  input  logic [31:0]                 byte_offset_i,
  input  logic [7:0]                  data_byte_i,
  input  logic                        byte_present_i,
  input  logic                        segment_eof_i,
  input  logic                        segment_last_i,
  output logic                        res_valid_o,
  input  logic                        res_stall_i,
  output logic [7:0]                  out_byte_o,
  output logic                        out_valid_o,
  output logic                        out_last_o,
  output logic                        stream_ended_o,
  output logic [6:0]                  pending_count_o,
  output sbr_pkg::sbr_cell_ctl_t      ctl_o,
  input  logic                        probe0_i,
  input  logic [7:0]                  byte0_i,
  input  logic                        any_hit_i
);
  import sbr_pkg::*;

  sbr_state_e       state_q, state_d;
  logic [31:0]      written_q, written_d;
  logic [CNT_W-1:0] pending_q, pending_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             eof_seen_q, eof_seen_d;
  logic [31:0]      eof_pos_q, eof_pos_d;
  logic             ended_q, ended_d;
  logic             seg_eof_q;
  logic [31:0]      eof_clip_q;

  logic             res_valid_q;
  logic [7:0]       res_byte_q;
  logic             res_flag_q;
  logic             res_last_q;
  logic             res_ended_q;
  logic [CNT_W-1:0] res_pend_q;

  logic [32:0]      win_hi;
  logic [31:0]      rel_full;
  logic [31:0]      written_n;
  logic             accept;
  logic             dropped;
  logic             in_window;
  logic             res_free;
  logic             push;
  logic             count_done;

  // Window bounds, computed without wrap
  assign win_hi   = {1'b0, written_q} + 33'(CAPACITY);
  assign dropped  = ({1'b0, segment_start_i} >= win_hi) || (segment_end_i < written_q);
  assign in_window = byte_present_i &&
                     (byte_offset_i >= segment_start_i) && (byte_offset_i < segment_end_i) &&
                     (byte_offset_i >= written_q) && ({1'b0, byte_offset_i} < win_hi);
  assign rel_full = byte_offset_i - written_q;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign res_free   = !res_valid_q || !res_stall_i;
  assign count_done = (state_q == ST_COUNT) && !probe0_i;
  assign written_n  = written_q + 32'(cnt_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && segment_last_i) begin
          state_d = dropped ? ST_NONE : ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (!probe0_i) begin
          state_d = (cnt_q == '0) ? ST_NONE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (res_free && (cnt_q == CNT_W'(1))) begin
          state_d = ST_IDLE;
        end
      end
      ST_NONE: begin
        if (res_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs for the cells and the result register
  always_comb begin
    ctl_o.wr_en       = accept && !dropped && in_window;
    ctl_o.wr_rel      = rel_full[IDX_W-1:0];
    ctl_o.wr_data     = data_byte_i;
    ctl_o.probe_load  = accept && segment_last_i && !dropped;
    ctl_o.probe_shift = (state_q == ST_COUNT) && probe0_i;
    ctl_o.shift       = 1'b0;
    push              = 1'b0;
    case (state_q)
      ST_EMIT: begin
        ctl_o.shift = res_free;
        push        = res_free;
      end
      ST_NONE: begin
        push = res_free;
      end
      default: begin
        ctl_o.shift = 1'b0;
        push        = 1'b0;
      end
    endcase
  end

  // Counters, eof tracking and end detection
  always_comb begin
    written_d  = written_q;
    pending_d  = pending_q;
    cnt_d      = cnt_q;
    eof_seen_d = eof_seen_q;
    eof_pos_d  = eof_pos_q;
    ended_d    = ended_q;
    if (any_hit_i && (pending_q < CNT_W'(CAPACITY))) begin
      pending_d = pending_q + CNT_W'(1);
    end
    if (accept) begin
      cnt_d = '0;
    end else if (ctl_o.probe_shift) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (push && (state_q == ST_EMIT)) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
    if (count_done) begin
      written_d  = written_n;
      pending_d  = pending_q - cnt_q;
      eof_seen_d = eof_seen_q | seg_eof_q;
      eof_pos_d  = seg_eof_q ? eof_clip_q : eof_pos_q;
      ended_d    = ended_q | (eof_seen_d && (eof_pos_d == written_n));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      written_q  <= '0;
      pending_q  <= '0;
      cnt_q      <= '0;
      eof_seen_q <= 1'b0;
      eof_pos_q  <= '0;
      ended_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      written_q  <= written_d;
      pending_q  <= pending_d;
      cnt_q      <= cnt_d;
      eof_seen_q <= eof_seen_d;
      eof_pos_q  <= eof_pos_d;
      ended_q    <= ended_d;
    end
  end

  // Segment end info captured on the last item
  always_ff @(posedge clk_i) begin
    if (accept && segment_last_i) begin
      seg_eof_q  <= segment_eof_i;
      eof_clip_q <= ({1'b0, segment_end_i} < win_hi) ? segment_end_i : win_hi[31:0];
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (push) begin
      res_valid_q <= 1'b1;
    end else if (!res_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      res_byte_q  <= (state_q == ST_EMIT) ? byte0_i : 8'd0;
      res_flag_q  <= (state_q == ST_EMIT);
      res_last_q  <= (state_q == ST_EMIT) ? (cnt_q == CNT_W'(1)) : 1'b1;
      res_ended_q <= ended_q;
      res_pend_q  <= pending_q;
    end
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign res_valid_o     = res_valid_q;
  assign out_byte_o      = res_byte_q;
  assign out_valid_o     = res_flag_q;
  assign out_last_o      = res_last_q;
  assign stream_ended_o  = res_ended_q;
  assign pending_count_o = 7'(res_pend_q);

endmodule

/* rtl/core/stream_byte_reassembler.sv */
// Top level of the stream byte reassembler: a row of window cells and the
// controller. Depends on sbr_pkg, sbr_cell and sbr_ctrl.
//
//   channel  valid        stall        payload
//   in       in_valid_i   in_stall_o   segment_start_i .. segment_last_i
//   result   res_valid_o  res_stall_i  out_byte_o .. pending_count_o
//
// An item that is not a segment's last leaves the block idle; its byte is written
// into the cell for its window position in the cycle the item is accepted.
// A last item holding an in-order run of n bytes is accepted; then the run
// is measured by shifting probe bits down the cell row, one cell a cycle, and
// the row shifts one byte a cycle into the result register unless stalled.
// A dropped segment gives one empty result with no measure; an empty run
// gives one empty result after the measure.
// Result stalls hold the drain; reset clears all held flags at once.
module stream_byte_reassembler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] segment_start_i,
  input  logic [31:0] segment_end_i,
  input  logic [31:0] byte_offset_i,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        segment_eof_i,
  input  logic        segment_last_i,
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        out_valid_o,
  output logic        out_last_o,
  output logic        stream_ended_o,
  output logic [6:0]  pending_count_o
);
  import sbr_pkg::*;

  sbr_cell_ctl_t       cell_ctl;
  logic [7:0]          chain_byte  [CAPACITY+1];
  logic                chain_held  [CAPACITY+1];
  logic                chain_probe [CAPACITY+1];
  logic [CAPACITY-1:0] hit_vec;

  // Past the window end nothing is held
  assign chain_byte[CAPACITY]  = 8'd0;
  assign chain_held[CAPACITY]  = 1'b0;
  assign chain_probe[CAPACITY] = 1'b0;

  // Cell row, position 0 is the next byte to write out
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sbr_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (cell_ctl),
      .idx_i       (IDX_W'(i)),
      .nxt_byte_i  (chain_byte[i+1]),
      .nxt_held_i  (chain_held[i+1]),
      .nxt_probe_i (chain_probe[i+1]),
      .byte_o      (chain_byte[i]),
      .held_o      (chain_held[i]),
      .probe_o     (chain_probe[i]),
      .hit_o       (hit_vec[i])
    );
  end

  sbr_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .segment_start_i (segment_start_i),
    .segment_end_i   (segment_end_i),
    .byte_offset_i   (byte_offset_i),
    .data_byte_i     (data_byte_i),
    .byte_present_i  (byte_present_i),
    .segment_eof_i   (segment_eof_i),
    .segment_last_i  (segment_last_i),
    .res_valid_o     (res_valid_o),
    .res_stall_i     (res_stall_i),
    .out_byte_o      (out_byte_o),
    .out_valid_o     (out_valid_o),
    .out_last_o      (out_last_o),
    .stream_ended_o  (stream_ended_o),
    .pending_count_o (pending_count_o),
    .ctl_o           (cell_ctl),
    .probe0_i        (chain_probe[0]),
    .byte0_i         (chain_byte[0]),
    .any_hit_i       (|hit_vec)
  );

endmodule

/* rtl/core/sbr_checker.sv */
// Port-level checker for the stream byte reassembler, bound to the top.
// Depends on stream_byte_reassembler_assert.svh.
`include "stream_byte_reassembler_assert.svh"

module sbr_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [31:0] segment_start_i,
  input  logic [31:0] segment_end_i,
  input  logic [31:0] byte_offset_i,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        segment_eof_i,
  input  logic        segment_last_i,
  input  logic        res_valid_o,
  input  logic        res_stall_i,
  input  logic [7:0]  out_byte_o,
  input  logic        out_valid_o,
  input  logic        out_last_o,
  input  logic        stream_ended_o,
  input  logic [6:0]  pending_count_o
);

  logic seen_end_q;

  // Remember a delivered request that reported the stream as ended
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_end_q <= 1'b0;
    end else if (res_valid_o && !res_stall_i && stream_ended_o) begin
      seen_end_q <= 1'b1;
    end
  end

  // An empty result carries no byte and closes its segment
  `SBR_ASSERT_IMP(a_empty_res, res_valid_o && !out_valid_o, (out_byte_o == 8'd0) && out_last_o, "empty result malformed")

  // End of stream never goes away once reported
  `SBR_ASSERT_IMP(a_end_sticky, res_valid_o && seen_end_q, stream_ended_o, "stream end dropped")

  // The last request of a segment always moves the block out of idle, so input stalls
  `SBR_ASSERT_NXT(a_last_busy, in_valid_i && !in_stall_o && segment_last_i, in_stall_o, "no stall after last")

  // Pending bytes never exceed the window
  `SBR_ASSERT_IMP(a_pend_max, res_valid_o, pending_count_o <= 7'd64, "pending count too large")

  // A stalled result holds
  `SBR_ASSERT_NXT(a_res_hold, res_valid_o && res_stall_i, res_valid_o && $stable(out_byte_o) && $stable(out_last_o), "stalled result changed")

endmodule

bind stream_byte_reassembler sbr_checker u_sbr_checker (.*);

/* tb/sv/tb_stream_byte_reassembler.sv */
// Self-checking testbench for stream_byte_reassembler: segment bytes go in out of
// order, and the in-order result stream is compared against a predictor in this file.
// Depends on sbr_pkg and the stream_byte_reassembler RTL.
module tb_stream_byte_reassembler;
  import sbr_pkg::*;

  localparam int SETTLE_CYCLES  = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 100;

  // One input request: a byte of a segment.
  typedef struct packed {
    logic [31:0] seg_start;
    logic [31:0] seg_end;
    logic [31:0] offset;
    logic [7:0]  data;
    logic        present;
    logic        eof;
    logic        last;
  } seg_item_t;

  // One result request as the block should emit it.
  typedef struct packed {
    logic [7:0] byte_val;
    logic       valid;
    logic       last;
    logic       ended;
    logic [6:0] pending;
  } out_rec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] segment_start_i = '0;
  logic [31:0] segment_end_i = '0;
  logic [31:0] byte_offset_i = '0;
  logic [7:0]  data_byte_i = '0;
  logic        byte_present_i = 1'b0;
  logic        segment_eof_i = 1'b0;
  logic        segment_last_i = 1'b0;
  logic        res_valid_o;
  logic        res_stall_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        out_valid_o;
  logic        out_last_o;
  logic        stream_ended_o;
  logic [6:0]  pending_count_o;

  stream_byte_reassembler dut (.*);

  always #1 clk_i = ~clk_i;

  // Predictor state: the reorder window and the stream bookkeeping.
  logic [7:0]       win_data [CAPACITY];
  bit               win_held [CAPACITY];
  logic [IDX_W-1:0] win_head    = '0;
  logic [31:0]      bytes_out   = '0;
  logic [6:0]       held_cnt    = '0;
  bit               eof_known   = 1'b0;
  logic [31:0]      eof_at      = '0;
  bit               stream_done = 1'b0;

  out_rec_t assembled_q [$];
  int       mismatch_count = 0;
  int       result_count   = 0;
  int       idle_cycles    = 0;
  bit       driving        = 1'b0;
  bit       send_idle_on   = 1'b1;
  bit       stall_idle_on  = 1'b1;

  // Mostly short pauses, now and then a long one.
  function automatic int pick_pause();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic seg_item_t mk_item(logic [31:0] s, logic [31:0] e, logic [31:0] o,
                                        logic [7:0] d, logic p, logic eof, logic last);
    seg_item_t it;
    it = '{s, e, o, d, p, eof, last};
    return it;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < MAX_REPORTS) $display("MISMATCH result %0d: %s", result_count, msg);
    mismatch_count++;
  endtask

  // Window bounds are taken one bit wider so that they never wrap.
  task automatic predict_reassembly(seg_item_t it);
    logic [32:0]      lo, hi, s33, e33, o33;
    logic [IDX_W-1:0] slot;
    logic [7:0]       run [CAPACITY];
    int               n;
    bit               dropped;
    out_rec_t         rec;
    lo  = {1'b0, bytes_out};
    hi  = lo + 33'(CAPACITY);
    s33 = {1'b0, it.seg_start};
    e33 = {1'b0, it.seg_end};
    o33 = {1'b0, it.offset};
    dropped = (s33 >= hi) || (e33 < lo);
    // store a byte that is inside both its segment and the window
    if (!dropped && it.present && o33 >= s33 && o33 < e33 && o33 >= lo && o33 < hi) begin
      slot = win_head + IDX_W'(o33 - lo);
      if (!win_held[slot]) begin
        win_data[slot] = it.data;
        win_held[slot] = 1'b1;
        if (held_cnt < CAPACITY) held_cnt++;
      end
    end
    if (!it.last) return;
    n = 0;
    if (!dropped) begin
      // drain the contiguous run at the window front
      while (n < CAPACITY && win_held[win_head]) begin
        run[n] = win_data[win_head];
        win_held[win_head] = 1'b0;
        win_head++;
        bytes_out++;
        if (held_cnt > 0) held_cnt--;
        n++;
      end
      if (it.eof) begin
        eof_known = 1'b1;
        eof_at = (e33 < hi) ? it.seg_end : hi[31:0];
      end
      if (eof_known && eof_at == bytes_out) stream_done = 1'b1;
    end
    if (n == 0) begin
      rec = '{8'h00, 1'b0, 1'b1, stream_done, held_cnt};
      assembled_q.push_back(rec);
    end else begin
      for (int k = 0; k < n; k++) begin
        rec = '{run[k], 1'b1, k == n - 1, stream_done, held_cnt};
        assembled_q.push_back(rec);
      end
    end
  endtask

  task automatic release_input();
    if (driving) begin
      in_valid_i <= 1'b0;
      driving = 1'b0;
    end
  endtask

  // Present one request and wait until the block takes it.
  task automatic send_item(seg_item_t it);
    int gap;
    gap = (send_idle_on && $urandom_range(0, 3) == 0) ? pick_pause() : 0;
    if (gap > 0) begin
      release_input();
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    segment_start_i <= it.seg_start;
    segment_end_i   <= it.seg_end;
    byte_offset_i   <= it.offset;
    data_byte_i     <= it.data;
    byte_present_i  <= it.present;
    segment_eof_i   <= it.eof;
    segment_last_i  <= it.last;
    driving = 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_reassembly(it);
  endtask

  // Whole segment, bytes in order, random payload.
  task automatic send_segment(logic [31:0] s, int len, bit eof);
    for (int i = 0; i < len; i++)
      send_item(mk_item(s, s + 32'(len), s + 32'(i), 8'($urandom), 1'b1, eof, i == len - 1));
  endtask

  task automatic wait_drained();
    release_input();
    while (assembled_q.size() != 0) @(posedge clk_i);
  endtask

  // Empty segment first, then the first three bytes, with the extreme values 00 and FF among them.
  task automatic test_first_bytes();
    send_item(mk_item(0, 0, 0, 8'h00, 1'b0, 1'b0, 1'b1));
    send_item(mk_item(0, 3, 0, 8'h00, 1'b1, 1'b0, 1'b0));
    send_item(mk_item(0, 3, 1, 8'hFF, 1'b1, 1'b0, 1'b0));
    send_item(mk_item(0, 3, 2, 8'h5A, 1'b1, 1'b0, 1'b1));
  endtask

  // A later segment is held until the gap in front of it is filled.
  task automatic test_reordered_segments();
    send_segment(7, 3, 1'b0);
    send_segment(3, 4, 1'b0);
  endtask

  task automatic test_window_limits();
    logic [31:0] w;
    w = bytes_out;
    // last window slot is kept, one past it is ignored
    send_item(mk_item(w + 62, w + 66, w + 63, 8'hC3, 1'b1, 1'b0, 1'b0));
    send_item(mk_item(w + 62, w + 66, w + 64, 8'h3C, 1'b1, 1'b0, 1'b1));
    // segments beyond the window or behind it are dropped with their eof
    send_item(mk_item(w + 64, w + 70, w + 64, 8'h11, 1'b1, 1'b1, 1'b1));
    send_item(mk_item('1, '1, '1, 8'hFF, 1'b1, 1'b1, 1'b1));
    send_item(mk_item(0, w - 5, w - 6, 8'h22, 1'b1, 1'b1, 1'b1));
    // byte outside its own segment
    send_item(mk_item(w + 2, w + 4, w + 5, 8'h33, 1'b1, 1'b0, 1'b1));
    // second copy of a held byte does not overwrite it
    send_item(mk_item(w + 1, w + 2, w + 1, 8'hAA, 1'b1, 1'b0, 1'b1));
    send_item(mk_item(w + 1, w + 2, w + 1, 8'h55, 1'b1, 1'b0, 1'b1));
    // segment reaching back over written bytes fills the front gap
    send_segment(w - 2, 3, 1'b0);
  endtask

  task automatic test_random_segments(int target);
    int          sent;
    int          kind;
    int          len;
    logic [31:0] w;
    logic [31:0] s;
    sent = 0;
    while (sent < target) begin
      kind = $urandom_range(0, 99);
      w = bytes_out;
      if (kind < 70) begin
        // well-formed segment near the window front
        if ($urandom_range(0, 9) == 0) begin
          len = $urandom_range(0, 1) ? 63 : $urandom_range(9, 64);
          s = (len == 63) ? w + 1 : w + $urandom_range(0, 8);
        end else begin
          len = $urandom_range(1, 8);
          case ($urandom_range(0, 4))
            0, 1:    s = w;
            2, 3:    s = w + $urandom_range(1, 48);
            default: s = (w >= 6) ? w - $urandom_range(1, 6) : w;
          endcase
        end
        send_segment(s, len, $urandom_range(0, 19) == 0);
        sent += len;
      end else if (kind < 78) begin
        // empty segment
        s = w + $urandom_range(0, 70);
        send_item(mk_item(s, s, s, 8'($urandom), 1'b0, $urandom_range(0, 19) == 0, 1'b1));
        sent++;
      end else if (kind < 90) begin
        // broken segment: stray offsets, missing bytes, maybe no last item
        s = w + $urandom_range(0, 40);
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          send_item(mk_item(s, s + 32'(len), s + $urandom_range(0, len + 3) - 2, 8'($urandom),
                            $urandom_range(0, 3) != 0, 1'b0,
                            (i == len - 1) && ($urandom_range(0, 1) == 1)));
        sent += len;
      end else begin
        // noise on every field
        send_item(mk_item($urandom, $urandom, $urandom, 8'($urandom), 1'($urandom),
                          1'($urandom), 1'($urandom)));
      end
    end
  endtask

  task automatic test_end_of_stream();
    logic [31:0] w;
    wait_drained();
    w = bytes_out;
    // malformed segment still records its eof
    send_item(mk_item(w + 10, w + 4, w + 5, 8'h77, 1'b1, 1'b1, 1'b1));
    send_segment(w, 4, 1'b0);
    // empty eof segment at the front, sent once the stream has already ended
    w = bytes_out;
    send_item(mk_item(w, w, w, 8'h00, 1'b0, 1'b1, 1'b1));
    // requests after the end are still processed
    send_segment(bytes_out, 2, 1'b0);
  endtask

  // Result side: random stall bursts.
  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_idle_on && $urandom_range(0, 3) == 0) begin
        res_stall_i <= 1'b1;
        repeat (pick_pause()) @(posedge clk_i);
        res_stall_i <= 1'b0;
      end
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    out_rec_t want;
    if (rst_ni && res_valid_o === 1'b1 && res_stall_i == 1'b0) begin
      if (assembled_q.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = assembled_q[0];
        assembled_q.delete(0);
        if (out_byte_o !== want.byte_val)
          report_mismatch($sformatf("out_byte %h want %h", out_byte_o, want.byte_val));
        if (out_valid_o !== want.valid)
          report_mismatch($sformatf("out_valid %b want %b", out_valid_o, want.valid));
        if (out_last_o !== want.last)
          report_mismatch($sformatf("out_last %b want %b", out_last_o, want.last));
        if (stream_ended_o !== want.ended)
          report_mismatch($sformatf("stream_ended %b want %b", stream_ended_o, want.ended));
        if (pending_count_o !== want.pending)
          report_mismatch($sformatf("pending_count %0d want %0d", pending_count_o,
                                    want.pending));
      end
      result_count++;
    end
  end

  // Watchdog: cycles with work outstanding but no request moving.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_stall_o === 1'b0) || (res_valid_o === 1'b1 && !res_stall_i) ||
          (!driving && assembled_q.size() == 0))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_first_bytes();
    test_reordered_segments();
    test_window_limits();
    test_random_segments(60);
    wait_drained();
    // stretch with no idling on either side
    send_idle_on  = 1'b0;
    stall_idle_on = 1'b0;
    test_random_segments(30);
    send_idle_on  = 1'b1;
    stall_idle_on = 1'b1;
    test_random_segments(50);
    test_end_of_stream();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && assembled_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
